// ----- rtl/ipv4_port_address_validator_assert.svh -----
// Assertion macros used by the checker file of the address validator.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef IPV4_PORT_ADDRESS_VALIDATOR_ASSERT_SVH
`define IPV4_PORT_ADDRESS_VALIDATOR_ASSERT_SVH

// Checked only outside reset.
`define IPA_ASSERT_ON(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define IPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/ipa_pkg.sv -----
// ----------------------------------------------------------------------------
// ipa_pkg
// Types and constants shared by the address validator modules.
// ----------------------------------------------------------------------------
package ipa_pkg;

  // One character of address text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // One verdict with the parsed values.
  typedef struct packed {
    logic        valid_res;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [15:0] port_number;
  } out_item_t;

  localparam logic [7:0]  CH_DOT     = 8'h2E;
  localparam logic [7:0]  CH_COLON   = 8'h3A;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [2:0]  PORT_FIELD = 3'd4;
  localparam logic [19:0] OCTET_MAX  = 20'd255;
  localparam logic [19:0] PORT_MAX   = 20'd65535;

  // Separator that must close each of the four address fields.
  function automatic logic [7:0] sep_char(input logic [1:0] idx);
    logic [7:0] s;
    case (idx)
      2'd3:    s = CH_COLON;
      default: s = CH_DOT;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ipv4_port_address_validator.sv -----
// A final character waits in the input register while a result is held, then loads the result register.
// Throughput: one character per cycle; the per-character update is one
// multiply-by-ten add and a few compares between the input and result registers.
// A held result stalls the input only when a final character waits behind it.
// Reset clears both stage valids and all parse state.
// ----------------------------------------------------------------------------
// ipv4_port_address_validator
// Strict parser for a.b.c.d:port text, one character per item.
// ----------------------------------------------------------------------------
module ipv4_port_address_validator (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  ipa_pkg::in_item_t  char_item,
  output logic               res_valid,
  input  logic               res_stall,
  output ipa_pkg::out_item_t res_item
);
  import ipa_pkg::*;

  logic      held_valid;
  in_item_t  held_item;
  logic      adv;
  logic      take;
  logic      out_ready;
  out_item_t verdict;

  // A character moves on unless it is final and the result register is full and stalled.
  assign adv  = !held_item.last || out_ready;
  assign take = held_valid && adv;

  ipa_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .adv        (adv),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipa_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (held_item),
    .result (verdict)
  );

  ipa_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && held_item.last),
    .load_item (verdict),
    .ready     (out_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

// ----- rtl/ipa_in_stage.sv -----
// ----------------------------------------------------------------------------
// ipa_in_stage
// Input register that holds one character until the parser takes it.
// ----------------------------------------------------------------------------
module ipa_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  input  ipa_pkg::in_item_t char_item,
  input  logic              adv,
  output logic              held_valid,
  output ipa_pkg::in_item_t held_item
);
  import ipa_pkg::*;

  logic load;

  // The register refills whenever it is empty or its item moves on.
  assign load       = !held_valid || adv;
  assign char_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && char_valid) begin
      held_item <= char_item;
    end
  end

endmodule

// ----- rtl/ipa_parser.sv -----
// ----------------------------------------------------------------------------
// ipa_parser
// Parse state for one address text and the per-character update logic.
// ----------------------------------------------------------------------------
module ipa_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  ipa_pkg::in_item_t  item,
  output ipa_pkg::out_item_t result
);
  import ipa_pkg::*;

  logic [2:0]  field_index,   field_index_next;
  logic [15:0] running_value, running_value_next;
  logic [1:0]  digit_count,   digit_count_next;
  logic        leading_zero,  leading_zero_next;
  logic        error_seen,    error_seen_next;
  logic [7:0]  saved_octets      [4];
  logic [7:0]  saved_octets_next [4];

  logic [19:0] scaled;
  logic [19:0] bound;
  logic        is_digit;
  logic        ok;

  // Running value times ten plus the new digit.
  assign scaled   = {1'b0, running_value, 3'b000} + {3'b000, running_value, 1'b0}
                  + {16'd0, item.ch[3:0] - CH_ZERO[3:0]};
  assign bound    = (field_index >= PORT_FIELD) ? PORT_MAX : OCTET_MAX;
  assign is_digit = item.ch inside {[CH_ZERO:CH_NINE]};

  // Next parse state after one character.
  always_comb begin
    field_index_next   = field_index;
    running_value_next = running_value;
    digit_count_next   = digit_count;
    leading_zero_next  = leading_zero;
    error_seen_next    = error_seen;
    saved_octets_next  = saved_octets;
    if (!error_seen) begin
      if (is_digit) begin
        if (digit_count != 2'd0 && leading_zero) begin
          error_seen_next = 1'b1;
        end else if (scaled > bound) begin
          error_seen_next = 1'b1;
        end else begin
          if (digit_count == 2'd0) begin
            leading_zero_next = (item.ch == CH_ZERO);
          end
          running_value_next = scaled[15:0];
          if (digit_count != 2'd2) begin
            digit_count_next = digit_count + 2'd1;
          end
        end
      end else if (field_index < PORT_FIELD && digit_count != 2'd0 &&
                   item.ch == sep_char(field_index[1:0])) begin
        saved_octets_next[field_index[1:0]] = running_value[7:0];
        field_index_next   = field_index + 3'd1;
        running_value_next = '0;
        digit_count_next   = '0;
        leading_zero_next  = 1'b0;
      end else begin
        error_seen_next = 1'b1;
      end
    end
  end

  // Verdict on the text as it stands after this character.
  assign ok = !error_seen_next && field_index_next == PORT_FIELD &&
              digit_count_next != 2'd0;

  always_comb begin
    result.valid_res   = ok;
    result.octet_a     = ok ? saved_octets_next[0] : '0;
    result.octet_b     = ok ? saved_octets_next[1] : '0;
    result.octet_c     = ok ? saved_octets_next[2] : '0;
    result.octet_d     = ok ? saved_octets_next[3] : '0;
    result.port_number = ok ? running_value_next : '0;
  end

  // State update; the final character returns everything to reset values.
  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      field_index   <= '0;
      running_value <= '0;
      digit_count   <= '0;
      leading_zero  <= 1'b0;
      error_seen    <= 1'b0;
      saved_octets  <= '{default: '0};
    end else if (take) begin
      field_index   <= field_index_next;
      running_value <= running_value_next;
      digit_count   <= digit_count_next;
      leading_zero  <= leading_zero_next;
      error_seen    <= error_seen_next;
      saved_octets  <= saved_octets_next;
    end
  end

endmodule

// ----- rtl/ipa_out_stage.sv -----
// ----------------------------------------------------------------------------
// ipa_out_stage
// Result register that holds a verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module ipa_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ipa_pkg::out_item_t load_item,
  output logic               ready,
  output logic               res_valid,
  input  logic               res_stall,
  output ipa_pkg::out_item_t res_item
);
  import ipa_pkg::*;

  // Room for a new result when empty or when the current one leaves now.
  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item <= load_item;
    end
  end

endmodule

// ----- rtl/ipa_checker.sv -----
// ----------------------------------------------------------------------------
// ipa_checker
// Port-level checks on the address validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "ipv4_port_address_validator_assert.svh"

module ipa_checker (
  input logic               clk,
  input logic               rst,
  input logic               char_valid,
  input logic               char_stall,
  input ipa_pkg::in_item_t  char_item,
  input logic               res_valid,
  input logic               res_stall,
  input ipa_pkg::out_item_t res_item
);
  import ipa_pkg::*;

  logic values_zero;
  logic final_taken;

  // All five value fields of the result read zero.
  assign values_zero = res_item.octet_a == 8'd0 && res_item.octet_b == 8'd0 &&
                       res_item.octet_c == 8'd0 && res_item.octet_d == 8'd0 &&
                       res_item.port_number == 16'd0;

  // A final character is accepted at this edge.
  assign final_taken = char_valid && !char_stall && char_item.last;

  // A stalled result stays offered.
  `IPA_ASSERT_ON(a_res_hold, res_valid && res_stall |=> res_valid, "result dropped under stall")

  // Reset leaves no result pending.
  `IPA_ASSERT_ALWAYS(a_rst_empty, rst |=> !res_valid, "result valid after reset")

  // A rejected text reports all values as zero.
  `IPA_ASSERT_ON(a_invalid_zero, res_valid && !res_item.valid_res |-> values_zero, "invalid values")

  // A new result follows an accepted final character.
  `IPA_ASSERT_ON(a_res_cause, $rose(res_valid) |-> $past(final_taken, 2), "result without cause")

endmodule

bind ipv4_port_address_validator ipa_checker u_ipa_checker (.*);
